### rtl/clbp_pkg.sv
package clbp_pkg;

  // Window geometry for a radius of one pixel.
  localparam int LBP_RADIUS = 1;
  localparam int LBP_DIAM   = 2 * LBP_RADIUS + 1;
  localparam int LBP_NLINES = 2 * LBP_RADIUS;
  localparam int LBP_WIN    = LBP_DIAM * LBP_DIAM;
  localparam int LBP_CENTER = LBP_RADIUS * LBP_DIAM + LBP_RADIUS;

  // Sampling circle: eight points, four bilinear taps each, 8 fraction bits.
  localparam int LBP_NB       = 8;
  localparam int LBP_TAPS     = 4;
  localparam int LBP_FRAC     = 8;
  localparam int LBP_WGT_W    = LBP_FRAC + 1;
  localparam int LBP_ACC_W    = LBP_WGT_W + 8 + 1;

  // Frame limits and counter widths.
  localparam int               LBP_CFG_W      = 11;
  localparam int               LBP_ROW_W      = 10;
  localparam logic [LBP_CFG_W-1:0] LBP_MAX_HEIGHT = 11'd1024;

  // Queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } clbp_reg_e;

  // Bilinear weights for each sample point; they sum to 256.
  localparam logic [LBP_WGT_W-1:0] LBP_WGT [LBP_NB][LBP_TAPS] = '{
    '{9'd256, 9'd0,   9'd0,   9'd0  },
    '{9'd53,  9'd128, 9'd22,  9'd53 },
    '{9'd256, 9'd0,   9'd0,   9'd0  },
    '{9'd128, 9'd53,  9'd53,  9'd22 },
    '{9'd256, 9'd0,   9'd0,   9'd0  },
    '{9'd53,  9'd22,  9'd128, 9'd53 },
    '{9'd256, 9'd0,   9'd0,   9'd0  },
    '{9'd22,  9'd53,  9'd53,  9'd128}
  };

  // Window position of each tap, row-major with the oldest line first.
  localparam logic [3:0] LBP_TAP [LBP_NB][LBP_TAPS] = '{
    '{4'd5, 4'd5, 4'd5, 4'd5},
    '{4'd1, 4'd2, 4'd4, 4'd5},
    '{4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd0, 4'd1, 4'd3, 4'd4},
    '{4'd3, 4'd3, 4'd3, 4'd3},
    '{4'd3, 4'd4, 4'd6, 4'd7},
    '{4'd7, 4'd7, 4'd7, 4'd7},
    '{4'd4, 4'd5, 4'd7, 4'd8}
  };

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } clbp_in_t;

  typedef struct packed {
    logic [7:0] lbp_code;
    logic       frame_last;
  } clbp_out_t;

  typedef struct packed {
    logic [LBP_WIN-1:0][7:0] win;
    logic                    last;
  } clbp_entry_t;

  typedef struct packed {
    logic        valid;
    clbp_entry_t entry;
  } clbp_push_t;

  typedef struct packed {
    logic        valid;
    clbp_entry_t entry;
  } clbp_head_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
  } clbp_qstat_t;

endpackage

### rtl/circular_lbp_pixel_stream.sv
// Circular local binary pattern over a raster pixel stream.
// Input channel: one 8-bit grayscale pixel per transaction in raster order,
// with frame_start marking row 0, column 0 of a frame. Output channel: one
// 8-bit code per interior pixel (one pixel away from every frame edge), with
// frame_last set on the code of the last interior pixel. Border pixels give
// no output transaction.
// A code is computed once the pixel one row below and one column right of
// its centre is accepted. Throughput is one pixel per cycle while
// in_stall_o is low; the line store is read and written once per pixel on
// separate ports. A four-entry queue separates the pixel front end from the
// pattern stage, so a stalled receiver lets the front keep taking pixels
// until the queue is full; then in_stall_o rises. The held result does not
// change while the receiver stalls.
// Frame width and height are set through the APB port, at byte addresses 0
// and 4, and may only change while the block is idle. Reset clears the
// position counters, empties the queue and loads 640 by 480; line store
// contents need no clearing.
module circular_lbp_pixel_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  clbp_pkg::clbp_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output clbp_pkg::clbp_out_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import clbp_pkg::*;

  logic [LBP_CFG_W-1:0] width_q, height_q;
  clbp_reg_e            reg_idx;
  logic                 cfg_wr;
  clbp_push_t           push;
  clbp_head_t           head;
  clbp_qstat_t          qstat;
  logic                 pop;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = clbp_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  width_q  <= pwdata[LBP_CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[LBP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = 32'(width_q);
      REG_IMAGE_HEIGHT: prdata = 32'(height_q);
      default:          prdata = '0;
    endcase
  end

  // Front end: position tracking, line store and window.
  clbp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .img_width_i  (width_q),
    .img_height_i (height_q),
    .qstat_i      (qstat),
    .push_o       (push)
  );

  clbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // Back end: interpolation, compare and output register.
  clbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/clbp_front.sv
module clbp_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  clbp_pkg::clbp_in_t               in_data_i,
  input  logic [clbp_pkg::LBP_CFG_W-1:0]   img_width_i,
  input  logic [clbp_pkg::LBP_CFG_W-1:0]   img_height_i,
  input  clbp_pkg::clbp_qstat_t            qstat_i,
  output clbp_pkg::clbp_push_t             push_o
);
  import clbp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  logic                   accept;
  logic [QLVL_W:0]        occupancy;
  logic [CW-1:0]          w_eff;
  logic [LBP_CFG_W-1:0]   h_eff;
  logic [CW-1:0]          col_q, col_d, cur_col;
  logic [LBP_ROW_W-1:0]   row_q, cur_row;
  logic [LBP_CFG_W-1:0]   row_t;
  logic [AW-1:0]          addr;
  logic                   interior, last;

  logic                   b_valid_q;
  logic [AW-1:0]          b_addr_q;
  logic [7:0]             b_px_q;
  logic                   b_int_q, b_last_q;

  logic [7:0]             line0_mem [MAX_WIDTH];
  logic [7:0]             line1_mem [MAX_WIDTH];
  logic [7:0]             rd0_q, rd1_q;
  logic                   fwd_q;
  logic [7:0]             fwd0_q, fwd1_q;
  logic [7:0]             colv0, colv1;

  logic [LBP_WIN-1:0][7:0] win_q, win_d;
  logic [LBP_DIAM-1:0][7:0] new_col;

  // Take a transaction only when the queue has room for it and for the one in flight.
  assign occupancy  = {1'b0, qstat_i.level} + (QLVL_W + 1)'(b_valid_q);
  assign in_stall_o = (occupancy >= (QLVL_W + 1)'(QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // Effective frame size after clamping.
  always_comb begin
    if (img_width_i == '0) begin
      w_eff = CW'(1);
    end else if (32'(img_width_i) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(img_width_i);
    end
    if (img_height_i == '0) begin
      h_eff = LBP_CFG_W'(1);
    end else if (img_height_i > LBP_MAX_HEIGHT) begin
      h_eff = LBP_MAX_HEIGHT;
    end else begin
      h_eff = img_height_i;
    end
  end

  // Position of the incoming pixel, wrapping at the row and frame ends.
  always_comb begin
    cur_col = col_q;
    row_t   = {1'b0, row_q};
    if (in_data_i.frame_start) begin
      cur_col = '0;
      row_t   = '0;
    end else begin
      if (col_q >= w_eff) begin
        cur_col = '0;
        row_t   = row_t + LBP_CFG_W'(1);
      end
      if (row_t >= h_eff) begin
        row_t = '0;
      end
    end
    cur_row  = row_t[LBP_ROW_W-1:0];
    col_d    = cur_col + CW'(1);
    addr     = cur_col[AW-1:0];
    interior = (cur_row >= LBP_ROW_W'(LBP_NLINES)) && (cur_col >= CW'(LBP_NLINES));
    last     = (({1'b0, cur_row} + LBP_CFG_W'(1)) == h_eff) && (col_d == w_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= cur_row;
      end
    end
  end

  // Second stage holds the transaction while the line store answers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_addr_q <= addr;
      b_px_q   <= in_data_i.pixel;
      b_int_q  <= interior;
      b_last_q <= last;
      fwd_q    <= b_valid_q && (b_addr_q == addr);
      fwd0_q   <= colv1;
      fwd1_q   <= b_px_q;
    end
  end

  // Column from the line store, bypassing a write to the same column still held in the second stage.
  assign colv0 = fwd_q ? fwd0_q : rd0_q;
  assign colv1 = fwd_q ? fwd1_q : rd1_q;

  // Oldest line: read on accept, written with the next line's old value.
  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      line0_mem[b_addr_q] <= colv1;
    end
    if (accept) begin
      rd0_q <= line0_mem[addr];
    end
  end

  // Newest stored line: read on accept, written with the incoming pixel.
  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      line1_mem[b_addr_q] <= b_px_q;
    end
    if (accept) begin
      rd1_q <= line1_mem[addr];
    end
  end

  // Shift the window left by one column and append the new column.
  always_comb begin
    new_col[0] = colv0;
    new_col[1] = colv1;
    new_col[2] = b_px_q;
    for (int y = 0; y < LBP_DIAM; y++) begin
      for (int x = 0; x < LBP_DIAM - 1; x++) begin
        win_d[y * LBP_DIAM + x] = win_q[y * LBP_DIAM + x + 1];
      end
      win_d[y * LBP_DIAM + LBP_DIAM - 1] = new_col[y];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      win_q <= win_d;
    end
  end

  // Interior positions go on to the back part.
  assign push_o.valid      = b_valid_q && b_int_q;
  assign push_o.entry.win  = win_d;
  assign push_o.entry.last = b_last_q;

endmodule

### rtl/clbp_queue.sv
module clbp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clbp_pkg::clbp_push_t  push_i,
  input  logic                  pop_i,
  output clbp_pkg::clbp_head_t  head_o,
  output clbp_pkg::clbp_qstat_t qstat_o
);
  import clbp_pkg::*;

  clbp_entry_t       slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLVL_W-1:0] level_q;

  // Ring pointers and fill level; the front never pushes into a full queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i.valid && !pop_i) begin
        level_q <= level_q + QLVL_W'(1);
      end else if (!push_i.valid && pop_i) begin
        level_q <= level_q - QLVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign head_o.valid   = (level_q != '0);
  assign head_o.entry   = slot_q[rd_ptr_q];
  assign qstat_o.level  = level_q;

endmodule

### rtl/clbp_back.sv
module clbp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clbp_pkg::clbp_head_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output clbp_pkg::clbp_out_t  out_data_o
);
  import clbp_pkg::*;

  logic                 out_valid_q;
  clbp_out_t            out_q;
  logic [LBP_NB-1:0]    code;
  logic [LBP_ACC_W-1:0] acc;
  logic [LBP_ACC_W-1:0] center;

  // Weighted sum of four taps per sample point, compared with the scaled centre.
  always_comb begin
    code   = '0;
    acc    = '0;
    center = LBP_ACC_W'({head_i.entry.win[LBP_CENTER], LBP_FRAC'(0)});
    for (int n = 0; n < LBP_NB; n++) begin
      acc = '0;
      for (int k = 0; k < LBP_TAPS; k++) begin
        acc = acc + LBP_ACC_W'(LBP_WGT[n][k]) *
                    LBP_ACC_W'(head_i.entry.win[LBP_TAP[n][k]]);
      end
      code[n] = (acc > center);
    end
  end

  // Output register: refilled whenever it is empty or being taken.
  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.lbp_code   <= code;
      out_q.frame_last <= head_i.entry.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/clbp_checker.sv
module clbp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input clbp_pkg::clbp_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input clbp_pkg::clbp_out_t out_data_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata,
  input logic                pready
);
  import clbp_pkg::*;

  logic seen_in_q;
  logic unused_pixel;

  assign unused_pixel = ^in_data_i;

  // Records whether any pixel transaction has been taken since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      seen_in_q <= 1'b1;
    end
  end

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled result does not change.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // No code can appear before any pixel has been taken.
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_in_q)
    else $error("output transaction without any input");

  // A register reads back what was just written to it.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(psel && penable && pwrite && pready) &&
    (paddr == $past(paddr)) |-> (prdata == 32'($past(pwdata[LBP_CFG_W-1:0]))))
    else $error("configuration readback mismatch");

endmodule

bind circular_lbp_pixel_stream clbp_checker u_clbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  import clbp_pkg::*;

  localparam int          IDLE_PCT        = 23;
  localparam int          SETTLE_CYCLES   = 12;
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          QUIET_LIMIT     = 4000;
  localparam int unsigned FRAME_CAP       = 1024;

  // Window cells are numbered row-major from the oldest line: 0 1 2 / 3 4 5 / 6 7 8,
  // with cell 4 as the centre. Point n lies n eighths of a turn anticlockwise from
  // the right-hand neighbour. Axis points fall exactly on a cell; diagonal points
  // blend four cells with fractions 181/256 and 75/256 per axis.
  localparam int unsigned TAP_CELL [8][4] = '{
    '{5, 5, 5, 5}, '{1, 2, 4, 5}, '{1, 1, 1, 1}, '{0, 1, 3, 4},
    '{3, 3, 3, 3}, '{3, 4, 6, 7}, '{7, 7, 7, 7}, '{4, 5, 7, 8}
  };
  localparam int unsigned TAP_WGT [8][4] = '{
    '{256, 0, 0, 0}, '{53, 128, 22, 53}, '{256, 0, 0, 0}, '{128, 53, 53, 22},
    '{256, 0, 0, 0}, '{53, 22, 128, 53}, '{256, 0, 0, 0}, '{22, 53, 53, 128}
  };

  // One row of the directed stimulus; pinned rows carry a result typed in by hand.
  typedef struct packed {
    logic [7:0] px;
    logic       fs;
    logic       pinned;
    logic [7:0] code;
    logic       last;
  } probe_t;

  localparam int NUM_PROBES = 23;
  localparam probe_t PROBES [NUM_PROBES] = '{
    // Flat 3x3 frame at full scale: no neighbour is strictly brighter.
    '{8'd255, 1'b1, 1'b0, 8'h00, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd255, 1'b0, 1'b1, 8'h00, 1'b1},
    // Black centre in a white ring: every neighbour is brighter.
    '{8'd255, 1'b1, 1'b0, 8'h00, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd0,   1'b0, 1'b0, 8'h00, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0}, '{8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd255, 1'b0, 1'b1, 8'hFF, 1'b1},
    // Next frame begins without a frame start mark.
    '{8'd0,   1'b0, 1'b0, 8'h00, 1'b0}, '{8'd128, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd77,  1'b0, 1'b0, 8'h00, 1'b0}, '{8'd1,   1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd254, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  clbp_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  clbp_out_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  circular_lbp_pixel_stream DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predictor state: line history, window, raster position and frame size.
  logic [7:0]  line_hist [2][FRAME_CAP];
  logic [7:0]  win_px [9];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [10:0] frame_w_cfg;
  logic [10:0] frame_h_cfg;

  clbp_out_t   code_q [$];
  clbp_out_t   seen_code;
  int          n_errors;
  int          pixels_sent;
  int          codes_checked;
  int          frame_ends;
  int          sizes_used;
  int          idle_pct;
  int          quiet_cycles;
  bit          hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input logic [10:0] v);
    if (v == 11'd0) return 1;
    if (v > FRAME_CAP) return FRAME_CAP;
    return 32'(v);
  endfunction

  // True when the next pixel lands on row 0, column 0 of a frame.
  function automatic bit next_is_origin();
    int unsigned c, r;
    c = col_pos;
    r = row_pos;
    if (c >= clamp_dim(frame_w_cfg)) begin
      c = 0;
      r++;
    end
    if (r >= clamp_dim(frame_h_cfg)) r = 0;
    return c == 0 && r == 0;
  endfunction

  // Advance the predictor by one pixel and work out the code it gives, if any.
  task automatic lbp_predict(input clbp_in_t px_in, output bit has_code,
                             output clbp_out_t res);
    int unsigned w, h, acc;
    logic [7:0]  up2, up1;
    w = clamp_dim(frame_w_cfg);
    h = clamp_dim(frame_h_cfg);
    if (px_in.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
    end
    up2 = line_hist[0][col_pos];
    up1 = line_hist[1][col_pos];
    line_hist[0][col_pos] = up1;
    line_hist[1][col_pos] = px_in.pixel;
    for (int y = 0; y < 3; y++) begin
      win_px[y*3]   = win_px[y*3+1];
      win_px[y*3+1] = win_px[y*3+2];
      win_px[y*3+2] = (y == 0) ? up2 : ((y == 1) ? up1 : px_in.pixel);
    end
    has_code = (row_pos >= 2) && (col_pos >= 2);
    res = '0;
    if (has_code) begin
      for (int n = 0; n < 8; n++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += TAP_WGT[n][k] * win_px[TAP_CELL[n][k]];
        res.lbp_code[n] = acc > (int'(win_px[4]) * 256);
      end
      res.frame_last = (row_pos == h - 1) && (col_pos == w - 1);
    end
    col_pos++;
  endtask

  // Offer one pixel, wait for the transaction and record what it should produce.
  task automatic send_pixel(input clbp_in_t px_in, input bit pinned,
                            input clbp_out_t pinned_res);
    bit        has_code;
    clbp_out_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px_in;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lbp_predict(px_in, has_code, res);
    if (pinned) code_q = {code_q, pinned_res};
    else if (has_code) code_q = {code_q, res};
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic apb_write(input clbp_reg_e idx, input logic [10:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {21'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input clbp_reg_e idx, input logic [10:0] want);
    logic [10:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata[10:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: register %s expected %0d, got %0d", $time, idx.name(), want, got);
      n_errors++;
    end
  endtask

  // Wait until every expected code has left, then for the pipeline to empty.
  task automatic wait_drained();
    while (code_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_frame_size(input logic [10:0] w, input logic [10:0] h);
    wait_drained();
    apb_write(REG_IMAGE_WIDTH, w);
    apb_write(REG_IMAGE_HEIGHT, h);
    check_reg(REG_IMAGE_WIDTH, w);
    check_reg(REG_IMAGE_HEIGHT, h);
    frame_w_cfg = w;
    frame_h_cfg = h;
    sizes_used++;
  endtask

  // One frame setting followed by a stream of pixels. Frame starts are mostly
  // marked where a frame begins, sometimes left out and now and then misplaced.
  task automatic run_phase(input logic [10:0] w, input logic [10:0] h, input int count,
                           input bit fresh, input bit squeeze);
    clbp_in_t   px_in;
    logic [7:0] level;
    int         near;
    set_frame_size(w, h);
    if (squeeze) hold_off_req = 1'b1;
    level = 8'($urandom_range(255));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) level = 8'($urandom_range(255));
      case ($urandom_range(3))
        0, 1: px_in.pixel = 8'($urandom_range(255));
        2: px_in.pixel = level;
        default: begin
          near = int'(level) + int'($urandom_range(8)) - 4;
          px_in.pixel = (near < 0) ? 8'd0 : ((near > 255) ? 8'd255 : near[7:0]);
        end
      endcase
      if (i == 0) px_in.frame_start = fresh;
      else if (next_is_origin()) px_in.frame_start = ($urandom_range(9) != 0);
      else px_in.frame_start = ($urandom_range(49) == 0);
      send_pixel(px_in, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Compare each output transaction with the oldest expected code.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (code_q.size() == 0) begin
        $display("%0t: unexpected code, expected none, got %02h last %0b", $time,
                 out_data_o.lbp_code, out_data_o.frame_last);
        n_errors++;
      end else begin
        seen_code = code_q.pop_front();
        codes_checked++;
        if (seen_code.frame_last) frame_ends++;
        if (out_data_o.lbp_code !== seen_code.lbp_code) begin
          $display("%0t: lbp_code expected %02h, got %02h", $time,
                   seen_code.lbp_code, out_data_o.lbp_code);
          n_errors++;
        end
        if (out_data_o.frame_last !== seen_code.frame_last) begin
          $display("%0t: frame_last expected %0b, got %0b", $time,
                   seen_code.frame_last, out_data_o.frame_last);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d codes outstanding", $time,
                 quiet_cycles, code_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    clbp_in_t  px_in;
    clbp_out_t pinned_res;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_off_req = 1'b0;
    idle_pct     = IDLE_PCT;
    quiet_cycles = 0;
    n_errors     = 0;
    pixels_sent  = 0;
    codes_checked = 0;
    frame_ends   = 0;
    sizes_used   = 0;
    col_pos      = 0;
    row_pos      = 0;
    frame_w_cfg  = 11'd640;
    frame_h_cfg  = 11'd480;
    for (int i = 0; i < 9; i++) win_px[i] = 8'd0;
    for (int i = 0; i < FRAME_CAP; i++) begin
      line_hist[0][i] = 8'd0;
      line_hist[1][i] = 8'd0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values of the frame size registers.
    check_reg(REG_IMAGE_WIDTH, 11'd640);
    check_reg(REG_IMAGE_HEIGHT, 11'd480);

    // Directed part on the smallest frame with an interior pixel.
    set_frame_size(11'd3, 11'd3);
    for (int i = 0; i < NUM_PROBES; i++) begin
      px_in.pixel           = PROBES[i].px;
      px_in.frame_start     = PROBES[i].fs;
      pinned_res.lbp_code   = PROBES[i].code;
      pinned_res.frame_last = PROBES[i].last;
      send_pixel(px_in, PROBES[i].pinned, pinned_res);
    end
    in_valid_i <= 1'b0;

    // Random part: small frames, a stretch without idling, a long receiver hold-off,
    // size changes part-way through a frame, clamped and degenerate sizes.
    run_phase(11'd3, 11'd3, 90, 1'b1, 1'b0);
    idle_pct = 0;
    run_phase(11'd12, 11'd6, 216, 1'b1, 1'b0);
    idle_pct = IDLE_PCT;
    run_phase(11'd7, 11'd5, 175, 1'b1, 1'b1);
    run_phase(11'd9, 11'd7, 34, 1'b1, 1'b0);
    run_phase(11'd5, 11'd7, 61, 1'b0, 1'b0);
    run_phase(11'd6, 11'd8, 40, 1'b1, 1'b0);
    run_phase(11'd6, 11'd4, 60, 1'b0, 1'b0);
    run_phase(11'd0, 11'd5, 20, 1'b1, 1'b0);
    run_phase(11'd2, 11'd6, 24, 1'b1, 1'b0);
    run_phase(11'd8, 11'd2, 24, 1'b1, 1'b0);
    run_phase(11'd5, 11'd0, 20, 1'b1, 1'b0);
    while (pixels_sent < 830) begin
      if ($urandom_range(7) == 0)
        run_phase(11'($urandom_range(3, 64)), 11'd3, 130, 1'b1, 1'b0);
      else
        run_phase(11'($urandom_range(3, 16)), 11'($urandom_range(3, 10)),
                  $urandom_range(20, 160), 1'b1, 1'b0);
    end
    run_phase(11'd2047, 11'd3, 100, 1'b1, 1'b0);
    run_phase(11'd3, 11'd2047, 60, 1'b1, 1'b0);

    wait_drained();
    if (code_q.size() != 0) begin
      $display("%0t: %0d expected codes never arrived", $time, code_q.size());
      n_errors++;
    end
    $display("Run covered %0d pixels, %0d codes checked, %0d frame ends, %0d frame sizes.",
             pixels_sent, codes_checked, frame_ends, sizes_used);
    $display("Included clamped and degenerate sizes, mid-frame size changes and a hold-off.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/clbp_pkg.sv
rtl/clbp_front.sv
rtl/clbp_queue.sv
rtl/clbp_back.sv
rtl/circular_lbp_pixel_stream.sv
rtl/clbp_checker.sv
bench/tb.sv
